/* src/soc_line_parser_checksum_unit_macros.svh */
// Assertion macros shared by the line parser and checksum unit.
// Included by every module that carries concurrent assertions.
`ifndef SOC_LINE_PARSER_CHECKSUM_UNIT_MACROS_SVH
`define SOC_LINE_PARSER_CHECKSUM_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked on i_clk and disabled while i_rst_n is low.
`define SLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Same check with an explicit clock and active-low reset.
`define SLP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define SLP_ASSERT(lbl, prop, msg)
`define SLP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

`endif

/* src/slp_pkg.sv */
// Shared types, constants and helper functions of the line parser and checksum unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package slp_pkg;

    localparam int SLP_LINE_KEEP = 80;

    localparam logic [15:0] SLP_MAX_AGE_RESET = 16'd30000;
    localparam logic [15:0] SLP_SOC_RESET     = 16'd500;

    localparam int SLP_SOC_LABEL_LEN = 3;
    localparam int SLP_CHK_LABEL_LEN = 8;

    localparam logic [7:0] SLP_CHAR_LF    = 8'h0A;
    localparam logic [7:0] SLP_CHAR_TAB   = 8'h09;
    localparam logic [7:0] SLP_CHAR_CR    = 8'h0D;
    localparam logic [7:0] SLP_CHAR_SPACE = 8'h20;
    localparam logic [7:0] SLP_CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] SLP_CHAR_MINUS = 8'h2D;
    localparam logic [7:0] SLP_CHAR_ZERO  = 8'h30;
    localparam logic [7:0] SLP_CHAR_NINE  = 8'h39;

    // Input kinds carried on the slave tuser bit.
    localparam logic SLP_CMD_BYTE = 1'b0;
    localparam logic SLP_CMD_TICK = 1'b1;

    // What the parser reports about the byte it is consuming.
    typedef struct packed {
        logic        newline;   // byte was a line feed
        logic        soc_hit;   // a SOC line ended here
        logic [15:0] soc_value; // parsed value of that line
        logic        chk_hit;   // a Checksum line ended here
    } t_line_evt;

    // One result item.
    typedef struct packed {
        logic [15:0] soc_report;
        logic        soc_fresh;
        logic        frame_end;
        logic        frame_good;
    } t_result;

    function automatic logic [7:0] soc_label_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h53; // S
            2'd1:    ch = 8'h4F; // O
            default: ch = 8'h43; // C
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] chk_label_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h43; // C
            3'd1:    ch = 8'h68; // h
            3'd2:    ch = 8'h65; // e
            3'd3:    ch = 8'h63; // c
            3'd4:    ch = 8'h6B; // k
            3'd5:    ch = 8'h73; // s
            3'd6:    ch = 8'h75; // u
            default: ch = 8'h6D; // m
        endcase
        return ch;
    endfunction

endpackage

/* src/soc_line_parser_checksum_unit.sv */
// Top level of the SOC line parser and checksum unit: stream ports and the two pipeline registers.
// Depends on slp_pkg, slp_line_parser, slp_frame_track and the assertion macro header.
`timescale 1ns / 1ps
`include "soc_line_parser_checksum_unit_macros.svh"

// This block watches a label-tab-value serial stream from a battery monitor. Each request on
// the slave side is either one received byte (tuser = 0) or a one millisecond tick (tuser = 1),
// and each request yields exactly one result on the master side. Every byte adds into an 8-bit
// running sum. Only the first LINE_KEEP bytes of a line are matched and parsed. When a line
// starting with "SOC" ends, the number after its first tab is parsed like atol into a pending
// value; when a line starting with "Checksum" ends, the pending value is committed and the age
// counter restarts if the sum is zero, and the sum clears. The result carries the committed SOC
// while it is fresh (age below the limit register) and zero otherwise, plus the fresh flag, the
// end-of-frame flag on tlast and the frame-good flag. The unit accepts one request per clock
// cycle while o_s_tready is high; a request waits in the input register and moves into the
// result register when that register is free or being emptied, so throughput is one result per
// cycle whenever the master side is ready. The parser and frame state are updated between the
// two registers. The limit register must be written by the user with i_cfg_wr_en only while no
// request is in flight; the block itself does not enforce this.
module soc_line_parser_checksum_unit
    import slp_pkg::*;
#(
    parameter int LINE_KEEP = SLP_LINE_KEEP
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,     // [0] cmd: 0 byte, 1 tick
    // Master result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,     // [15:0] soc_report, [16] soc_fresh,
                                       // [17] frame_good, [23:18] zero
    output logic        o_m_tlast,     // frame_end
    // Limit register write port.
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    // Input register: holds the request until the state update can run on it.
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;

    // Result register: one finished result waiting for the master side.
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       byte_vld;
    t_line_evt  line_evt;
    t_result    res;

    // The state update fires when the input register is full and the result register
    // is free or being emptied in this same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign byte_vld   = advance && (r_in_cmd == SLP_CMD_BYTE);
    assign o_s_tready = !r_in_valid || advance;

    slp_line_parser #(
        .LINE_KEEP (LINE_KEEP)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (byte_vld),
        .i_byte     (r_in_byte),
        .o_evt      (line_evt)
    );

    slp_frame_track u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_cmd         (r_in_cmd),
        .i_byte        (r_in_byte),
        .i_evt         (line_evt),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd  <= i_s_tuser[0];
            r_in_byte <= i_s_tdata;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.frame_good, r_out.soc_fresh, r_out.soc_report};
    assign o_m_tlast  = r_out.frame_end;

    `SLP_ASSERT(a_out_from_in, $rose(o_m_tvalid) |-> $past(r_in_valid), "result appeared without a request")
    `SLP_ASSERT(a_stall_cause, !o_s_tready |-> r_in_valid && r_out_valid && !i_m_tready, "input stalled without a full pipeline")
    `SLP_ASSERT(a_good_has_end, o_m_tvalid && o_m_tdata[17] |-> o_m_tlast, "frame good flagged outside a frame end")

endmodule

/* src/slp_line_parser.sv */
// Per-line state: position count, label matching and atol-style value parsing.
// Depends on slp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "soc_line_parser_checksum_unit_macros.svh"

module slp_line_parser
    import slp_pkg::*;
#(
    parameter int LINE_KEEP = SLP_LINE_KEEP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_vld,
    input  logic [7:0] i_byte,
    output t_line_evt  o_evt
);

    localparam int CNT_W = $clog2(LINE_KEEP + 1);

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_STOP   = 3'b100
    } t_phase;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_soc_match, n_soc_match;
    logic             r_chk_match, n_chk_match;
    logic             r_tab, n_tab;
    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [15:0]      r_accum, n_accum;

    logic       keep;
    logic       is_nl;
    logic       is_digit;
    logic       is_space;
    logic [3:0] dval;

    always_comb begin
        keep     = (r_count < CNT_W'(LINE_KEEP));
        is_nl    = (i_byte == SLP_CHAR_LF);
        is_digit = (i_byte >= SLP_CHAR_ZERO) && (i_byte <= SLP_CHAR_NINE);
        is_space = (i_byte == SLP_CHAR_SPACE) ||
                   ((i_byte >= SLP_CHAR_TAB) && (i_byte <= SLP_CHAR_CR));
        dval     = i_byte[3:0];

        n_count     = r_count;
        n_soc_match = r_soc_match;
        n_chk_match = r_chk_match;
        n_tab       = r_tab;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_accum     = r_accum;

        if (keep) begin
            if ((r_count < CNT_W'(SLP_SOC_LABEL_LEN)) &&
                (i_byte != soc_label_char(r_count[1:0]))) begin
                n_soc_match = 1'b0;
            end
            if ((r_count < CNT_W'(SLP_CHK_LABEL_LEN)) &&
                (i_byte != chk_label_char(r_count[2:0]))) begin
                n_chk_match = 1'b0;
            end
            if (!is_nl) begin
                if (!r_tab) begin
                    if (i_byte == SLP_CHAR_TAB) begin
                        n_tab   = 1'b1;
                        n_phase = PH_SKIP;
                        n_neg   = 1'b0;
                        n_accum = '0;
                    end
                end else begin
                    unique case (r_phase)
                        PH_SKIP: begin
                            if (is_space) begin
                                n_phase = PH_SKIP;
                            end else if ((i_byte == SLP_CHAR_PLUS) ||
                                         (i_byte == SLP_CHAR_MINUS)) begin
                                n_neg   = (i_byte == SLP_CHAR_MINUS);
                                n_phase = PH_DIGITS;
                            end else if (is_digit) begin
                                n_accum = 16'(dval);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_phase = PH_STOP;
                            end
                        end
                        PH_DIGITS: begin
                            if (is_digit) begin
                                n_accum = (r_accum << 3) + (r_accum << 1) + 16'(dval);
                            end else begin
                                n_phase = PH_STOP;
                            end
                        end
                        PH_STOP: begin
                            n_phase = PH_STOP;
                        end
                        default: begin
                            n_phase = PH_STOP;
                        end
                    endcase
                end
            end
            n_count = r_count + CNT_W'(1);
        end

        // Line events use the count and matches that include this byte.
        o_evt.newline   = i_byte_vld && is_nl;
        o_evt.soc_hit   = o_evt.newline && n_soc_match &&
                          (n_count >= CNT_W'(SLP_SOC_LABEL_LEN));
        o_evt.chk_hit   = o_evt.newline && n_chk_match &&
                          (n_count >= CNT_W'(SLP_CHK_LABEL_LEN));
        o_evt.soc_value = r_tab ? (r_neg ? (16'd0 - r_accum) : r_accum) : 16'd0;

        if (is_nl) begin
            n_count     = '0;
            n_soc_match = 1'b1;
            n_chk_match = 1'b1;
            n_tab       = 1'b0;
            n_phase     = PH_SKIP;
            n_neg       = 1'b0;
            n_accum     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_soc_match <= 1'b1;
            r_chk_match <= 1'b1;
            r_tab       <= 1'b0;
            r_phase     <= PH_SKIP;
            r_neg       <= 1'b0;
            r_accum     <= '0;
        end else if (i_byte_vld) begin
            r_count     <= n_count;
            r_soc_match <= n_soc_match;
            r_chk_match <= n_chk_match;
            r_tab       <= n_tab;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_accum     <= n_accum;
        end
    end

    `SLP_ASSERT(a_count_bounded, r_count <= CNT_W'(LINE_KEEP), "line count beyond keep limit")
    `SLP_ASSERT(a_no_tab_idle, !r_tab |-> (r_phase == PH_SKIP) && (r_accum == 16'd0) && !r_neg, "number state busy before tab")
    `SLP_ASSERT(a_nl_clears, o_evt.newline |=> (r_count == '0) && r_soc_match && r_chk_match, "line state not cleared after newline")

endmodule

/* src/slp_frame_track.sv */
// Running byte sum, pending and committed SOC, age counter and the limit register.
// Depends on slp_pkg and the assertion macro header; fed by slp_line_parser events.
`timescale 1ns / 1ps
`include "soc_line_parser_checksum_unit_macros.svh"

module slp_frame_track
    import slp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_cmd,
    input  logic [7:0]  i_byte,
    input  t_line_evt   i_evt,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output t_result     o_res
);

    logic [15:0] r_max_age;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_pending, n_pending;
    logic [15:0] r_committed, n_committed;
    logic [15:0] r_age, n_age;
    logic        good;

    always_comb begin
        n_sum       = r_sum;
        n_pending   = r_pending;
        n_committed = r_committed;
        n_age       = r_age;
        good        = 1'b0;

        if (i_cmd == SLP_CMD_TICK) begin
            if (r_age < r_max_age) begin
                n_age = r_age + 16'd1;
            end
        end else begin
            n_sum = r_sum + i_byte;
            // A line cannot carry both labels, so the commit sees the old pending value.
            if (i_evt.soc_hit) begin
                n_pending = i_evt.soc_value;
            end
            if (i_evt.chk_hit) begin
                good = (n_sum == 8'd0);
                if (good) begin
                    n_committed = r_pending;
                    n_age       = '0;
                end
                n_sum = '0;
            end
        end

        o_res.soc_fresh  = (n_age < r_max_age);
        o_res.soc_report = o_res.soc_fresh ? n_committed : 16'd0;
        o_res.frame_end  = (i_cmd == SLP_CMD_BYTE) && i_evt.chk_hit;
        o_res.frame_good = good;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age   <= SLP_MAX_AGE_RESET;
            r_sum       <= '0;
            r_pending   <= '0;
            r_committed <= SLP_SOC_RESET;
            r_age       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_age <= i_cfg_wr_data;
            end
            if (i_en) begin
                r_sum       <= n_sum;
                r_pending   <= n_pending;
                r_committed <= n_committed;
                r_age       <= n_age;
            end
        end
    end

    `SLP_ASSERT(a_good_restarts_age, i_en && o_res.frame_good |=> r_age == 16'd0, "age not restarted on good frame")
    `SLP_ASSERT(a_good_commits, i_en && o_res.frame_good |=> r_committed == $past(r_pending), "pending value not committed")
    `SLP_ASSERT(a_frame_clears_sum, i_en && o_res.frame_end |=> r_sum == 8'd0, "sum not cleared at frame end")

endmodule
